[hdl/smie_pkg.sv]
package smie_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned DepthW = 7;

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_CONST0 = 4'd1,
    OP_CONST1 = 4'd2,
    OP_DUP    = 4'd3,
    OP_SWAP   = 4'd4,
    OP_ROT    = 4'd5,
    OP_ROTN   = 4'd6,
    OP_ADD    = 4'd7,
    OP_SUB    = 4'd8,
    OP_MUL    = 4'd9,
    OP_DIV    = 4'd10,
    OP_REM    = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_DIV,
    S_RV_RD,
    S_RV_WAIT,
    S_RV_WR,
    S_TOP_RD,
    S_TOP_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_rem;
  } div_ctl_t;

endpackage

[hdl/stack_machine_int_executor.sv]
// Operand-stack integer executor.
// Input channel: in_valid/in_stall carry op and imm; one instruction per transfer.
// Result channel: out_valid/out_stall carry top_value, depth and status; exactly
// one result transfer for every input transfer, in order.
// The stack lives in one synchronous single-port memory (registered read).
// The block works on one instruction at a time and stalls input while busy.
// The time from the input transfer to out_valid depends on the instruction and, for
// rotn, grows with the number of entries reversed. It is set by the single memory
// port and by the bit-serial divider, which works out one quotient bit per cycle.
// The result is held in output registers; while out_stall is high the result
// stays put. The next instruction may still be taken and executed, but its
// result waits until the held one has gone.
// Reset (rst_n low, synchronous) empties the stack and clears the handshakes;
// memory contents are left as they are, since only written entries are read.
module stack_machine_int_executor #(
  parameter int unsigned STACK_DEPTH = smie_pkg::DefStackDepth
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        in_op,
  input  logic signed [smie_pkg::DataW-1:0] in_imm,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [smie_pkg::DataW-1:0] out_top_value,
  output logic [smie_pkg::DepthW-1:0]       out_depth,
  output logic [1:0]                        out_status
);
  import smie_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  logic [DataW-1:0] mem [STACK_DEPTH];
  logic [DataW-1:0] rd_data;
  logic             we;
  logic [AW-1:0]    addr;
  logic [DataW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_data <= mem[addr];
  end

  state_t state_r, state_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [3:0]        op_r;
  logic [DataW-1:0]  a_r, a_nxt;
  logic [DataW-1:0]  b_r, b_nxt;
  logic [SPW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic              ph_r, ph_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              ov_r, ov_nxt;
  logic [DataW-1:0]  top_r, top_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [DepthW-1:0] odep_r, odep_nxt;
  logic              div_done;
  logic [DataW-1:0]  div_res;
  div_ctl_t          dctl;
  logic [DataW-1:0]  mul_p;

  assign mul_p = a_r * b_r;

  smie_divider u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl),
    .dividend(a_r), .divisor(b_r), .done(div_done), .result(div_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_top_value = top_r;
  assign out_depth = odep_r;
  assign out_status = ost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      ov_r    <= ov_nxt;
    end
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_op;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ph_r   <= ph_nxt;
    st_r   <= st_nxt;
    top_r  <= top_nxt;
    ost_r  <= ost_nxt;
    odep_r <= odep_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r;
    a_nxt = a_r;
    b_nxt = b_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    ph_nxt = ph_r;
    st_nxt = st_r;
    top_nxt = top_r;
    ost_nxt = ost_r;
    odep_nxt = odep_r;
    ov_nxt = ov_r && out_stall;
    we = 1'b0;
    addr = AW'(sp_r - 1'b1);
    wdata = a_r;
    dctl = '{start: 1'b0, is_rem: (op_r == OP_REM)};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_OK;
          state_nxt = S_TOP_RD;
          case (in_op)
            OP_PUSH, OP_CONST0, OP_CONST1: begin
              if (sp_r >= SPW'(STACK_DEPTH)) st_nxt = ST_OVER;
              else begin
                we = 1'b1;
                addr = AW'(sp_r);
                wdata = (in_op == OP_PUSH) ? in_imm :
                        (in_op == OP_CONST1) ? DataW'(1) : '0;
                sp_nxt = sp_r + 1'b1;
              end
            end
            OP_DUP: begin
              if (sp_r < SPW'(1)) st_nxt = ST_UNDER;
              else if (sp_r >= SPW'(STACK_DEPTH)) st_nxt = ST_OVER;
              else state_nxt = S_RD1;
            end
            OP_SWAP, OP_ROT: begin
              if (sp_r < ((in_op == OP_SWAP) ? SPW'(2) : SPW'(3))) st_nxt = ST_UNDER;
              else begin
                lo_nxt = sp_r - ((in_op == OP_SWAP) ? SPW'(2) : SPW'(3));
                hi_nxt = sp_r - 1'b1;
                ph_nxt = 1'b0;
                state_nxt = S_RV_RD;
              end
            end
            OP_ROTN: begin
              if (in_imm[DataW-1] || (DataW'(unsigned'(in_imm)) > DataW'(sp_r)))
                st_nxt = ST_UNDER;
              else if (in_imm > 1) begin
                lo_nxt = sp_r - SPW'(in_imm);
                hi_nxt = sp_r - 1'b1;
                ph_nxt = 1'b0;
                state_nxt = S_RV_RD;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
              if (sp_r < SPW'(2)) st_nxt = ST_UNDER;
              else state_nxt = S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        addr = AW'(sp_r - 1'b1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        addr = AW'(sp_r - 2'd2);
        a_nxt = rd_data;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (op_r == OP_DUP) begin
          we = 1'b1;
          addr = AW'(sp_r);
          wdata = a_r;
          sp_nxt = sp_r + 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          b_nxt = rd_data;
          ph_nxt = 1'b0;
          state_nxt = S_DIV;
          if (op_r == OP_DIV || op_r == OP_REM) begin
            if (rd_data == '0) begin
              st_nxt = ST_DIVZ;
              state_nxt = S_TOP_RD;
            end
          end
        end
      end
      S_DIV: begin
        // b_r valid here; arithmetic finishes in this state.
        if (op_r == OP_DIV || op_r == OP_REM) begin
          if (!ph_r) begin
            dctl.start = 1'b1;
            ph_nxt = 1'b1;
          end else if (div_done) begin
            we = 1'b1;
            addr = AW'(sp_r - 2'd2);
            wdata = div_res;
            sp_nxt = sp_r - 1'b1;
            ph_nxt = 1'b0;
            state_nxt = S_TOP_RD;
          end
        end else begin
          we = 1'b1;
          addr = AW'(sp_r - 2'd2);
          wdata = (op_r == OP_ADD) ? a_r + b_r :
                  (op_r == OP_SUB) ? a_r - b_r : mul_p;
          sp_nxt = sp_r - 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_RV_RD: begin
        addr = AW'(lo_r);
        state_nxt = S_RV_WAIT;
      end
      S_RV_WAIT: begin
        addr = AW'(hi_r);
        a_nxt = rd_data;
        state_nxt = S_RV_WR;
      end
      S_RV_WR: begin
        // With ph_r clear it writes hi into lo; with ph_r set, it writes lo into hi.
        we = 1'b1;
        if (!ph_r) begin
          addr = AW'(lo_r);
          wdata = rd_data;
          b_nxt = rd_data;
          ph_nxt = 1'b1;
        end else begin
          addr = AW'(hi_r);
          wdata = a_r;
          ph_nxt = 1'b0;
          lo_nxt = lo_r + 1'b1;
          hi_nxt = hi_r - 1'b1;
          state_nxt = ((lo_r + 1'b1) < (hi_r - 1'b1)) ? S_RV_RD : S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        addr = AW'(sp_r - 1'b1);
        state_nxt = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The result fields are captured here so a following instruction
        // cannot disturb a result that is still waiting for its transfer.
        if (!ov_r || !out_stall) begin
          top_nxt = (sp_r == '0) ? '0 : rd_data;
          ost_nxt = st_r;
          odep_nxt = DepthW'(sp_r);
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/smie_divider.sv]
module smie_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smie_pkg::div_ctl_t            ctl,
  input  logic [smie_pkg::DataW-1:0]    dividend,
  input  logic [smie_pkg::DataW-1:0]    divisor,
  output logic                          done,
  output logic [smie_pkg::DataW-1:0]    result
);
  import smie_pkg::*;

  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             neg_q_r, neg_r_r, is_rem_r;
  logic [DataW:0]   trial;
  logic [DataW-1:0] a_abs, b_abs;

  assign a_abs = dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
  assign b_abs = divisor[DataW-1] ? (~divisor + 1'b1) : divisor;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial   = {rem_r, quo_r[DataW-1]} - {1'b0, dvs_r};
    quo_nxt = {quo_r[DataW-2:0], ~trial[DataW]};
    rem_nxt = trial[DataW] ? {rem_r[DataW-2:0], quo_r[DataW-1]} : trial[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        quo_r    <= a_abs;
        rem_r    <= '0;
        dvs_r    <= b_abs;
        neg_q_r  <= dividend[DataW-1] ^ divisor[DataW-1];
        neg_r_r  <= dividend[DataW-1];
        is_rem_r <= ctl.is_rem;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DataW - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_rem_r) result = neg_r_r ? (~rem_r + 1'b1) : rem_r;
    else          result = neg_q_r ? (~quo_r + 1'b1) : quo_r;
  end

endmodule

[tb/stack_machine_int_executor_test.sv]
`timescale 1ns / 100ps

// Expected results of the operand-stack executor, kept in issue order.
class stack_result_board;
  typedef struct {
    logic signed [31:0] top_value;
    logic [6:0]         depth;
    logic [1:0]         status;
  } result_t;

  logic [31:0] stack_mem [64];
  int unsigned sp;
  result_t     pending [$];
  int          mismatch_count;

  function new();
    sp = 0;
    mismatch_count = 0;
  endfunction

  function void flip_top(int unsigned n);
    int unsigned lo;
    int unsigned hi;
    logic [31:0] t;
    lo = sp - n;
    hi = sp - 1;
    while (lo < hi) begin
      t = stack_mem[lo];
      stack_mem[lo] = stack_mem[hi];
      stack_mem[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  function smie_pkg::status_t push_word(logic [31:0] v);
    if (sp >= 64) return smie_pkg::ST_OVER;
    stack_mem[sp] = v;
    sp++;
    return smie_pkg::ST_OK;
  endfunction

  // Computes the outcome of one accepted instruction and queues it.
  function void note_instruction(logic [3:0] op, logic [31:0] imm);
    smie_pkg::status_t st;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0] r;
    result_t res;
    st = smie_pkg::ST_OK;
    case (op)
      smie_pkg::OP_PUSH:   st = push_word(imm);
      smie_pkg::OP_CONST0: st = push_word(32'd0);
      smie_pkg::OP_CONST1: st = push_word(32'd1);
      smie_pkg::OP_DUP: begin
        if (sp < 1) st = smie_pkg::ST_UNDER;
        else st = push_word(stack_mem[sp-1]);
      end
      smie_pkg::OP_SWAP: begin
        if (sp < 2) st = smie_pkg::ST_UNDER;
        else flip_top(2);
      end
      smie_pkg::OP_ROT: begin
        if (sp < 3) st = smie_pkg::ST_UNDER;
        else flip_top(3);
      end
      smie_pkg::OP_ROTN: begin
        if (imm[31] || imm > sp) st = smie_pkg::ST_UNDER;
        else if (imm > 1) flip_top(imm);
      end
      smie_pkg::OP_ADD, smie_pkg::OP_SUB, smie_pkg::OP_MUL,
      smie_pkg::OP_DIV, smie_pkg::OP_REM: begin
        if (sp < 2) st = smie_pkg::ST_UNDER;
        else begin
          a = stack_mem[sp-1];
          b = stack_mem[sp-2];
          if ((op == smie_pkg::OP_DIV || op == smie_pkg::OP_REM) && b == 0)
            st = smie_pkg::ST_DIVZ;
          else begin
            case (op)
              smie_pkg::OP_ADD: r = a + b;
              smie_pkg::OP_SUB: r = a - b;
              smie_pkg::OP_MUL: r = a * b;
              smie_pkg::OP_DIV: r = (b == -1) ? -a : a / b;
              default:          r = (b == -1) ? 32'sd0 : a % b;
            endcase
            sp--;
            stack_mem[sp-1] = r;
          end
        end
      end
      default: ;
    endcase
    res.top_value = (sp != 0) ? stack_mem[sp-1] : 32'd0;
    res.depth = sp[6:0];
    res.status = st;
    pending.push_back(res);
  endfunction

  function void check_result(logic signed [31:0] top_value, logic [6:0] depth,
                             logic [1:0] status);
    result_t e;
    if (pending.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result transfer: top %0d depth %0d status %0d",
                 top_value, depth, status);
      return;
    end
    e = pending.pop_front();
    if (e.top_value !== top_value || e.depth !== depth || e.status !== status) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected top %0d depth %0d status %0d, got %0d %0d %0d",
                 e.top_value, e.depth, e.status, top_value, depth, status);
    end
  endfunction
endclass

module stack_machine_int_executor_test;
  import smie_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic signed [31:0] in_imm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_top_value;
  logic [6:0] out_depth;
  logic [1:0] out_status;

  stack_result_board board = new();
  int unsigned cycle_count = 0;
  int stall_left = 0;
  // Once set, neither side inserts idle cycles any more.
  bit steady = 1'b0;

  stack_machine_int_executor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_imm(in_imm),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_top_value(out_top_value), .out_depth(out_depth), .out_status(out_status)
  );

  always #2 clk = ~clk;

  // A result transfer is checked at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_top_value, out_depth, out_status);
    if (rst_n && in_valid && !in_stall)
      board.note_instruction(in_op, in_imm);
  end

  // The receiver stalls in random bursts until the steady phase begins.
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 17);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one instruction and holds it until the transfer happens. Valid
  // stays high afterwards so the next instruction can follow directly; it is
  // dropped only before an idle gap or a drain.
  task automatic send_instruction(input logic [3:0] op, input logic [31:0] imm);
    int gap;
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_imm <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Random operand with a bias toward the interesting corners.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed programs: operators are only picked when the stack can
  // feed them, with occasional faults, bad counts and unused opcodes mixed in.
  task automatic random_instruction();
    int unsigned depth;
    int unsigned pick;
    logic [31:0] imm;
    depth = board.sp;
    pick = $urandom_range(0, 99);
    imm = pick_operand();
    if (pick < 5) begin
      send_instruction(4'($urandom_range(12, 15)), $urandom);
    end else if (pick < 12) begin
      send_instruction(4'($urandom_range(OP_PUSH, OP_REM)), $urandom);
    end else if (depth < 3 || (depth < 40 && pick < 45)) begin
      case ($urandom_range(0, 3))
        0: send_instruction(OP_CONST0, imm);
        1: send_instruction(OP_CONST1, imm);
        2: send_instruction(OP_DUP, imm);
        default: send_instruction(OP_PUSH, imm);
      endcase
    end else if (pick < 60) begin
      if ($urandom_range(0, 9) == 0)
        imm = $urandom_range(0, 1) ? $urandom : depth + $urandom_range(1, 3);
      else
        imm = $urandom_range(0, (depth > 12 && $urandom_range(0, 5) != 0) ? 12 : depth);
      send_instruction(OP_ROTN, imm);
    end else begin
      send_instruction(4'($urandom_range(OP_SWAP, OP_REM)), $urandom);
    end
  endtask

  initial begin
    int unsigned i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Faults on an empty stack, then the field extremes.
    send_instruction(OP_DUP, 32'd0);
    send_instruction(OP_ADD, 32'd0);
    send_instruction(OP_ROTN, 32'd0);
    send_instruction(OP_ROTN, 32'd1);
    send_instruction(OP_PUSH, 32'hFFFF_FFFF);
    send_instruction(OP_PUSH, 32'h8000_0000);
    send_instruction(OP_DIV, 32'd0);          // min divided by minus one
    send_instruction(OP_PUSH, 32'hFFFF_FFFF);
    send_instruction(OP_PUSH, 32'h8000_0000);
    send_instruction(OP_REM, 32'd0);
    send_instruction(OP_CONST0, 32'd0);
    send_instruction(OP_PUSH, 32'h7FFF_FFFF);
    send_instruction(OP_DIV, 32'd0);          // zero divisor
    send_instruction(OP_REM, 32'd0);
    send_instruction(OP_CONST1, 32'd0);
    send_instruction(OP_PUSH, -32'sd7);
    send_instruction(OP_ROT, 32'd0);
    send_instruction(OP_SWAP, 32'd0);
    send_instruction(OP_ROTN, 32'h8000_0000); // negative count
    send_instruction(OP_ROTN, 32'd9);         // count beyond depth
    send_instruction(OP_ROTN, 32'd4);
    send_instruction(OP_MUL, 32'd0);
    send_instruction(OP_SUB, 32'd0);
    send_instruction(4'd15, 32'hFFFF_FFFF);
    // Fill to the top so pushes overflow, then a full-depth reverse.
    drain_results();
    while (board.sp < 64) send_instruction(OP_DUP, 32'd0);
    send_instruction(OP_CONST1, 32'd0);
    send_instruction(OP_DUP, 32'd0);
    send_instruction(OP_ROTN, 32'd64);

    // Let everything drain before the sender resumes.
    drain_results();
    for (i = 0; i < 1750; i++) begin
      if (i == 1500) steady = 1'b1;
      if (i == 800) drain_results();
      random_instruction();
    end
    drain_results();
    repeat (200) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
